### rtl/ibar_pkg.sv
// Shared types and constants for the input binding autorepeat block.
package ibar_pkg;

    // Number of bindings that are stored and scanned (1 to 8)
    localparam logic [3:0] BIND_COUNT = 4'd8;

    // Address width of the per-binding stores (binding_index is 3 bits)
    localparam int unsigned IDX_W = 3;

    // Operation codes of a command beat
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Active set range and the "every set" key code
    localparam logic [2:0] SET_ALL = 3'd0;
    localparam logic [2:0] SET_MIN = 3'd1;
    localparam logic [2:0] SET_MAX = 3'd4;

    // Command beat: a value event or a millisecond tick
    typedef struct packed {
        logic               operation;
        logic [2:0]         binding_index;
        logic signed [15:0] input_value;
    } ibar_in_t;

    // Result beat: one firing of a binding
    typedef struct packed {
        logic [2:0] fired_binding;
        logic       send_key;
        logic       rumble_pulse;
        logic [2:0] active_set;
        logic       last;
    } ibar_out_t;

    // Layout of one 58-bit binding configuration word
    typedef struct packed {
        logic               prev_set;
        logic               next_set;
        logic               rumble;
        logic [2:0]         key_set;
        logic [11:0]        period;
        logic [11:0]        delay;
        logic [11:0]        hold;
        logic signed [15:0] threshold;
    } ibar_binding_t;

    // Per-binding timestamps kept in the time RAM
    typedef struct packed {
        logic [31:0] press_time;
        logic [31:0] first_time;
        logic [31:0] last_time;
    } ibar_times_t;

endpackage

### rtl/ibar_time_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ibar_time_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned WIDTH = 96,
    parameter int unsigned AW    = 3
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/ibar_cfg_regs.sv
// Binding configuration register file with write decode and one read port.
module ibar_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [57:0]           cfg_data,
    input  logic [2:0]            rd_index,
    output ibar_pkg::ibar_binding_t rd_word
);

    ibar_pkg::ibar_binding_t word_reg [ibar_pkg::BIND_COUNT];

    // writes past the last binding are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(ibar_pkg::BIND_COUNT); i++)
            begin
                word_reg[i] <= '0;
            end
        end
        else if (cfg_write && ({1'b0, cfg_index} < ibar_pkg::BIND_COUNT))
        begin
            word_reg[cfg_index] <= ibar_pkg::ibar_binding_t'(cfg_data);
        end
    end

    assign rd_word = word_reg[rd_index];

endmodule

### rtl/input_binding_autorepeat_core.sv
// Top level: event qualification, tick scan and firing output of the autorepeat block.
//
// Usage:
//   cfg_write/cfg_index/cfg_data load the eight 58-bit binding words; write only
//   while the block is idle. A write to an index past the last binding is dropped.
//   The cmd channel (valid/ready) takes value events and millisecond ticks.
//   An event beat never yields a result.
//   A tick beat advances the millisecond clock and scans the bindings one per
//   cycle unless the fire channel stalls, reading each binding's timestamps from
//   the time RAM (registered read, write-back in the cycle the binding is checked).
//   Each firing gives one beat on the fire channel; a firing is held one stage
//   until the next firing or the end of the scan tells whether it carries last.
//   An output register parts the fire channel from the scan: when the receiver
//   stalls, the scan waits at the next firing or at the end of the scan, and
//   cmd_ready stays low until the tick's scan is done.
//   Reset clears the clock, press flags and output valid, and sets the active
//   set to 1; the timestamps in the RAM are only used after they are written.
module input_binding_autorepeat_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [57:0]         cfg_data,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ibar_pkg::ibar_in_t  cmd,
    output logic                fire_valid,
    input  logic                fire_ready,
    output ibar_pkg::ibar_out_t fire
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [31:0]                   now_reg, now_next;
    logic [2:0]                    set_reg, set_next;
    logic [ibar_pkg::BIND_COUNT-1:0] pressed_reg, pressed_next;
    logic [ibar_pkg::BIND_COUNT-1:0] fired_reg, fired_next;
    logic [2:0]                    scan_idx_reg, scan_idx_next;
    logic                          pend_valid_reg, pend_valid_next;
    ibar_pkg::ibar_out_t           pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;
    ibar_pkg::ibar_out_t           out_reg, out_next;

    ibar_pkg::ibar_binding_t       word;
    logic [2:0]                    cfg_rd_index;
    ibar_pkg::ibar_times_t         times_rd;
    ibar_pkg::ibar_times_t         times_wr;
    logic [95:0]                   ram_rd_data;
    logic                          ram_wr_en;
    logic [2:0]                    ram_wr_addr;
    logic                          ram_rd_en;
    logic [2:0]                    ram_rd_addr;

    logic                          cmd_acc;
    logic                          press;
    logic                          idx_ok;
    logic [31:0]                   el_press;
    logic [31:0]                   el_first;
    logic [31:0]                   el_last;
    logic                          due;
    logic                          first;
    logic                          out_free;
    logic                          last_scan;
    logic                          advance;
    logic                          push;
    ibar_pkg::ibar_out_t           push_data;
    ibar_pkg::ibar_out_t           fire_res;
    logic [2:0]                    set_fire;
    logic                          send;

    // binding words
    ibar_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .rd_index (cfg_rd_index),
        .rd_word  (word)
    );

    // per-binding timestamps
    ibar_time_ram #(
        .DEPTH(int'(ibar_pkg::BIND_COUNT)),
        .WIDTH($bits(ibar_pkg::ibar_times_t)),
        .AW   (ibar_pkg::IDX_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(times_wr),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign times_rd     = ibar_pkg::ibar_times_t'(ram_rd_data);
    assign cmd_ready    = (state_reg == S_IDLE);
    assign cmd_acc      = cmd_valid && cmd_ready;
    assign cfg_rd_index = (state_reg == S_IDLE) ? cmd.binding_index : scan_idx_reg;
    assign out_free     = !out_valid_reg || fire_ready;
    assign last_scan    = (scan_idx_reg == 3'(ibar_pkg::BIND_COUNT - 4'd1));
    assign fire_valid   = out_valid_reg;
    assign fire         = out_reg;

    // event qualification: at or past the threshold in its sign
    always_comb
    begin
        idx_ok = ({1'b0, cmd.binding_index} < ibar_pkg::BIND_COUNT);
        press  = ((cmd.input_value > 16'sd0) && (word.threshold > 16'sd0) &&
                  (cmd.input_value >= word.threshold)) ||
                 ((cmd.input_value < 16'sd0) && (word.threshold < 16'sd0) &&
                  (cmd.input_value <= word.threshold));
    end

    // due check for the binding under scan, elapsed times modulo 2^32
    always_comb
    begin
        el_press = now_reg - times_rd.press_time;
        el_first = now_reg - times_rd.first_time;
        el_last  = now_reg - times_rd.last_time;
        due      = 1'b0;
        first    = 1'b0;
        if (pressed_reg[scan_idx_reg])
        begin
            if (!fired_reg[scan_idx_reg])
            begin
                first = 1'b1;
                due   = (word.hold == 12'd0) || (el_press >= {20'd0, word.hold});
            end
            else
            begin
                due = (el_first >= {20'd0, word.delay}) &&
                      (el_last >= {20'd0, word.period});
            end
        end
    end

    // set stepping and key decision for a firing
    always_comb
    begin
        set_fire = set_reg;
        send     = 1'b0;
        if (word.next_set)
        begin
            if (set_reg < ibar_pkg::SET_MAX)
            begin
                set_fire = set_reg + 3'd1;
            end
        end
        else if (word.prev_set)
        begin
            if (set_reg > ibar_pkg::SET_MIN)
            begin
                set_fire = set_reg - 3'd1;
            end
        end
        else
        begin
            send = (word.key_set == ibar_pkg::SET_ALL) || (word.key_set == set_reg);
        end
        fire_res.fired_binding = scan_idx_reg;
        fire_res.send_key      = send;
        fire_res.rumble_pulse  = word.rumble;
        fire_res.active_set    = set_fire;
        fire_res.last          = 1'b0;
    end

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        set_next        = set_reg;
        pressed_next    = pressed_reg;
        fired_next      = fired_reg;
        scan_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = scan_idx_reg;
        times_wr        = times_rd;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_idx_reg;
        advance         = 1'b0;
        push            = 1'b0;
        push_data       = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc && (cmd.operation == ibar_pkg::OP_TICK))
                begin
                    now_next      = now_reg + 32'd1;
                    scan_idx_next = 3'd0;
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = 3'd0;
                    state_next    = S_SCAN;
                end
                else if (cmd_acc && idx_ok)
                begin
                    // value event
                    if (press)
                    begin
                        if (!pressed_reg[cmd.binding_index])
                        begin
                            pressed_next[cmd.binding_index] = 1'b1;
                            fired_next[cmd.binding_index]   = 1'b0;
                            ram_wr_en                       = 1'b1;
                            ram_wr_addr                     = cmd.binding_index;
                            times_wr.press_time             = now_reg;
                            times_wr.first_time             = '0;
                            times_wr.last_time              = '0;
                        end
                    end
                    else
                    begin
                        pressed_next[cmd.binding_index] = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // a new firing moves the held one out, which needs a free output
                advance = !(due && pend_valid_reg && !out_free);
                if (advance)
                begin
                    if (due)
                    begin
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_next       = fire_res;
                        set_next        = set_fire;
                        ram_wr_en       = 1'b1;
                        times_wr.last_time = now_reg;
                        if (first)
                        begin
                            times_wr.first_time       = now_reg;
                            fired_next[scan_idx_reg]  = 1'b1;
                        end
                    end
                    if (last_scan)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 3'd1;
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = scan_idx_reg + 3'd1;
                    end
                end
            end

            S_FIN:
            begin
                // flush the held firing, if any, with last set
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push            = 1'b1;
                    push_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register
        out_valid_next = out_valid_reg && !fire_ready;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_data;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            set_reg        <= ibar_pkg::SET_MIN;
            pressed_reg    <= '0;
            fired_reg      <= '0;
            scan_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            set_reg        <= set_next;
            pressed_reg    <= pressed_next;
            fired_reg      <= fired_next;
            scan_idx_reg   <= scan_idx_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // a push never overwrites a beat the receiver has not taken
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("fire beat overwritten");

    // no firing is held while the block takes commands
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !pend_valid_reg)
        else $error("held firing while idle");

    // the active set stays within its range
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        (set_reg >= ibar_pkg::SET_MIN) && (set_reg <= ibar_pkg::SET_MAX))
        else $error("active set out of range");

    // an accepted tick starts a scan from binding zero
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (cmd.operation == ibar_pkg::OP_TICK)) |=>
        ((state_reg == S_SCAN) && (scan_idx_reg == 3'd0)))
        else $error("tick did not start a scan");

endmodule

### bench/tb_input_binding_autorepeat_core.sv
`timescale 1ns / 1ps
// Self-checking bench for the binding autorepeat core: predicts firings per command beat.
module tb_input_binding_autorepeat_core;

    localparam int SETTLE_CYCLES = 3 * (int'(ibar_pkg::BIND_COUNT) + 2);
    localparam int GAP_PCT       = 14;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_BEATS   = 28;
    localparam int LONG_TICKS    = 20;
    localparam longint RUN_LIMIT = 64'd1_000_000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [2:0]              cfg_index = '0;
    logic [57:0]             cfg_data = '0;
    logic                    cmd_valid = 1'b0;
    logic                    cmd_ready;
    ibar_pkg::ibar_in_t      cmd = '0;
    logic                    fire_valid;
    logic                    fire_ready = 1'b0;
    ibar_pkg::ibar_out_t     fire;

    // Command beats waiting to be driven, firings waiting to be seen
    ibar_pkg::ibar_in_t      cmd_backlog[$];
    ibar_pkg::ibar_out_t     firings_due[$];
    ibar_pkg::ibar_out_t     fire_want;
    logic                    cmd_taken = 1'b0;
    logic                    steady = 1'b0;
    int                      fail_count = 0;

    // Shadow of the block: binding words, clock, press flags, timestamps, set
    ibar_pkg::ibar_binding_t bind_cfg [8];
    ibar_pkg::ibar_binding_t next_words [8];
    logic [31:0]             clock_ms;
    logic                    held [8];
    logic                    fired [8];
    logic [31:0]             t_press [8];
    logic [31:0]             t_first [8];
    logic [31:0]             t_last [8];
    logic [2:0]              cur_set;

    input_binding_autorepeat_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .fire_valid (fire_valid),
        .fire_ready (fire_ready),
        .fire       (fire)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the shadow for one accepted command beat; queue the firings it causes
    task automatic track_command(input ibar_pkg::ibar_in_t b);
        ibar_pkg::ibar_out_t hits [8];
        ibar_pkg::ibar_out_t r;
        int                  n;
        int                  i;
        logic signed [15:0]  v;
        logic signed [15:0]  thr;
        logic                hit;
        logic                is_first;
        n = 0;
        if (b.operation == ibar_pkg::OP_EVENT)
        begin
            if (b.binding_index < ibar_pkg::BIND_COUNT)
            begin
                v = b.input_value;
                thr = bind_cfg[b.binding_index].threshold;
                // pressed only at or past a nonzero threshold, same sign
                if ((v > 0 && thr > 0 && v >= thr) || (v < 0 && thr < 0 && v <= thr))
                begin
                    if (!held[b.binding_index])
                    begin
                        held[b.binding_index] = 1'b1;
                        fired[b.binding_index] = 1'b0;
                        t_press[b.binding_index] = clock_ms;
                    end
                end
                else
                    held[b.binding_index] = 1'b0;
            end
        end
        else
        begin
            clock_ms = clock_ms + 32'd1;
            for (i = 0; i < int'(ibar_pkg::BIND_COUNT); i++)
            begin
                hit = 1'b0;
                is_first = 1'b0;
                if (held[i])
                begin
                    if (!fired[i])
                    begin
                        if ((clock_ms - t_press[i]) >= bind_cfg[i].hold)
                        begin
                            hit = 1'b1;
                            is_first = 1'b1;
                        end
                    end
                    else if ((clock_ms - t_first[i]) >= bind_cfg[i].delay &&
                             (clock_ms - t_last[i]) >= bind_cfg[i].period)
                        hit = 1'b1;
                end
                if (hit)
                begin
                    t_last[i] = clock_ms;
                    if (is_first)
                    begin
                        t_first[i] = clock_ms;
                        fired[i] = 1'b1;
                    end
                    r = '0;
                    // next-set wins over previous-set; only plain keys send
                    if (bind_cfg[i].next_set)
                    begin
                        if (cur_set < ibar_pkg::SET_MAX)
                            cur_set = cur_set + 3'd1;
                    end
                    else if (bind_cfg[i].prev_set)
                    begin
                        if (cur_set > ibar_pkg::SET_MIN)
                            cur_set = cur_set - 3'd1;
                    end
                    else
                        r.send_key = (bind_cfg[i].key_set == ibar_pkg::SET_ALL) ||
                                     (bind_cfg[i].key_set == cur_set);
                    r.fired_binding = 3'(i);
                    r.rumble_pulse = bind_cfg[i].rumble;
                    r.active_set = cur_set;
                    hits[n] = r;
                    n++;
                end
            end
            for (i = 0; i < n; i++)
            begin
                r = hits[i];
                r.last = (i == n - 1);
                firings_due.push_back(r);
            end
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic ibar_pkg::ibar_binding_t binding(logic signed [15:0] thr,
                                                        logic [11:0] hold,
                                                        logic [11:0] delay,
                                                        logic [11:0] period,
                                                        logic [2:0] kset, logic rum,
                                                        logic nxt, logic prv);
        ibar_pkg::ibar_binding_t w;
        w.threshold = thr;
        w.hold = hold;
        w.delay = delay;
        w.period = period;
        w.key_set = kset;
        w.rumble = rum;
        w.next_set = nxt;
        w.prev_set = prv;
        return w;
    endfunction

    function automatic ibar_pkg::ibar_binding_t random_word();
        ibar_pkg::ibar_binding_t w;
        w = '0;
        case ($urandom_range(0, 9))
            0: w.threshold = 16'sd0;
            1: w.threshold = 16'sd1;
            2: w.threshold = -16'sd1;
            3: w.threshold = 16'sh7FFF;
            4: w.threshold = 16'sh8000;
            5, 6: w.threshold = 16'($urandom_range(1, 300));
            7: w.threshold = -16'($urandom_range(1, 300));
            default: w.threshold = 16'($urandom);
        endcase
        // mostly short times so firings come often; now and then the longest hold or delay
        w.hold = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 4));
        w.delay = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 6));
        w.period = 12'($urandom_range(0, 3));
        w.key_set = 3'($urandom_range(0, 7));
        w.rumble = 1'($urandom);
        w.next_set = ($urandom_range(0, 3) == 0);
        w.prev_set = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    function automatic ibar_pkg::ibar_in_t tick_cmd();
        ibar_pkg::ibar_in_t c;
        c.operation = ibar_pkg::OP_TICK;
        c.binding_index = 3'($urandom);
        c.input_value = 16'($urandom);
        return c;
    endfunction

    function automatic ibar_pkg::ibar_in_t value_cmd(int idx, logic signed [15:0] v);
        ibar_pkg::ibar_in_t c;
        c.operation = ibar_pkg::OP_EVENT;
        c.binding_index = 3'(idx);
        c.input_value = v;
        return c;
    endfunction

    // Values near the threshold, zero and the rails, or anything at all
    function automatic logic signed [15:0] pick_value(logic signed [15:0] thr);
        case ($urandom_range(0, 7))
            0: return thr;
            1: return thr - 16'sd1;
            2: return thr + 16'sd1;
            3: return 16'sd0;
            4: return 16'sh7FFF;
            5: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ibar_pkg::ibar_in_t random_command();
        ibar_pkg::ibar_in_t c;
        c = tick_cmd();
        if ($urandom_range(0, 99) >= 55)
        begin
            c.operation = ibar_pkg::OP_EVENT;
            if ($urandom_range(0, 3) != 0)
                c.input_value = pick_value(bind_cfg[c.binding_index].threshold);
        end
        return c;
    endfunction

    // Write all eight binding words from next_words, block idle
    task automatic load_bindings();
        int i;
        for (i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= next_words[i];
            bind_cfg[i] = next_words[i];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every command is taken and every firing seen, then let a scan finish
    task automatic drain_and_settle();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || cmd_valid || firings_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Command driver: new beat only once the previous one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_taken)
            begin
                if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= GAP_PCT))
                begin
                    cmd <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
            fire_ready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    // Monitor: predict on each command beat, check each fire beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_taken <= cmd_valid && cmd_ready;
            if (cmd_valid && cmd_ready)
                track_command(cmd);
            if (fire_valid && fire_ready)
            begin
                if (firings_due.size() == 0)
                begin
                    $display("%0t: unexpected firing, expected none, got binding %0d set %0d",
                             $time, fire.fired_binding, fire.active_set);
                    fail_count++;
                end
                else
                begin
                    fire_want = firings_due.pop_front();
                    check_field("fired_binding", fire_want.fired_binding, fire.fired_binding);
                    check_field("send_key", fire_want.send_key, fire.send_key);
                    check_field("rumble_pulse", fire_want.rumble_pulse, fire.rumble_pulse);
                    check_field("active_set", fire_want.active_set, fire.active_set);
                    check_field("last", fire_want.last, fire.last);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int i;
        int ph;
        int left;
        int chunk;
        clock_ms = '0;
        cur_set = ibar_pkg::SET_MIN;
        for (i = 0; i < 8; i++)
        begin
            bind_cfg[i] = '0;
            held[i] = 1'b0;
            fired[i] = 1'b0;
            t_press[i] = '0;
            t_first[i] = '0;
            t_last[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: rails, zero threshold, step priority, sets that never match
        next_words[0] = binding(16'sd1, 12'd0, 12'd0, 12'd0, ibar_pkg::SET_ALL,
                                1'b0, 1'b0, 1'b0);
        next_words[1] = binding(16'sh8000, 12'd2, 12'd3, 12'd2, 3'd1, 1'b1, 1'b0, 1'b0);
        next_words[2] = binding(16'sh7FFF, 12'd1, 12'd0, 12'd1, 3'd2, 1'b0, 1'b1, 1'b0);
        next_words[3] = binding(-16'sd1, 12'd0, 12'd2, 12'd0, 3'd3, 1'b1, 1'b1, 1'b1);
        next_words[4] = binding(16'sd0, 12'd0, 12'd0, 12'd0, ibar_pkg::SET_ALL,
                                1'b0, 1'b0, 1'b0);
        next_words[5] = binding(16'sd100, 12'd0, 12'd1, 12'd1, 3'd5, 1'b0, 1'b0, 1'b0);
        next_words[6] = binding(-16'sd200, 12'd0, 12'd0, 12'd2, 3'd4, 1'b0, 1'b0, 1'b1);
        next_words[7] = binding(16'sd500, 12'd3, 12'd4, 12'd3, 3'd2, 1'b1, 1'b0, 1'b0);
        load_bindings();
        cmd_backlog.push_back(value_cmd(0, 16'sh7FFF));
        cmd_backlog.push_back(value_cmd(0, 16'sd1));       // press while pressed
        cmd_backlog.push_back(value_cmd(1, 16'sh8000));
        cmd_backlog.push_back(value_cmd(2, 16'sh7FFF));
        cmd_backlog.push_back(value_cmd(3, 16'sh8000));
        cmd_backlog.push_back(value_cmd(4, 16'sh7FFF));    // zero threshold
        cmd_backlog.push_back(value_cmd(4, 16'sh8000));
        cmd_backlog.push_back(value_cmd(5, 16'sd100));
        cmd_backlog.push_back(value_cmd(6, -16'sd200));
        cmd_backlog.push_back(value_cmd(7, 16'sd499));     // just short of threshold
        cmd_backlog.push_back(value_cmd(7, 16'sd500));
        repeat (5) cmd_backlog.push_back(tick_cmd());
        cmd_backlog.push_back(value_cmd(0, 16'sd0));
        cmd_backlog.push_back(value_cmd(2, -16'sd5));      // wrong sign releases
        cmd_backlog.push_back(value_cmd(3, 16'sd5));
        repeat (6) cmd_backlog.push_back(tick_cmd());
        drain_and_settle();

        // Random phases, each with fresh binding words
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (i = 0; i < 8; i++)
                next_words[i] = random_word();
            load_bindings();
            steady = (ph == 1);
            left = PHASE_BEATS;
            while (left > 0)
            begin
                chunk = $urandom_range(6, 14);
                if (chunk > left)
                    chunk = left;
                left -= chunk;
                repeat (chunk) cmd_backlog.push_back(random_command());
                // sometimes hold off until every firing has come back
                if ($urandom_range(0, 3) == 0)
                    drain_and_settle();
                else
                    while (cmd_backlog.size() != 0) @(posedge clk);
            end
            drain_and_settle();
        end
        steady = 1'b0;

        // Longest times: all-ones word, all-zero word, 4095 ms hold/delay/period
        next_words[0] = '1;
        next_words[1] = '0;
        next_words[2] = binding(16'sh7FFF, 12'd0, 12'hFFF, 12'hFFF, 3'd4, 1'b0, 1'b0, 1'b0);
        next_words[3] = binding(16'sh8000, 12'hFFF, 12'd0, 12'd0, ibar_pkg::SET_ALL,
                                1'b1, 1'b0, 1'b0);
        for (i = 4; i < 8; i++)
            next_words[i] = '0;
        load_bindings();
        cmd_backlog.push_back(value_cmd(0, 16'sh8000));
        cmd_backlog.push_back(value_cmd(1, 16'sh7FFF));
        cmd_backlog.push_back(value_cmd(2, 16'sh7FFF));
        cmd_backlog.push_back(value_cmd(3, 16'sh8000));
        repeat (LONG_TICKS) cmd_backlog.push_back(tick_cmd());
        drain_and_settle();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
